>>> hdl/pp4_pkg.sv
// Shared types and constants of the 4D-to-3D perspective projection block.
// Used by pp4_divider, perspective_project_4d_to_3d and pp4_checker.
package pp4_pkg;

  // Coordinate word width. The fraction bits cancel in v * num / den, so they
  // never show up in the datapath.
  localparam int COORD_BITS = 32;
  // Differences of two coordinates need one more bit.
  localparam int NUM_W      = COORD_BITS + 1;
  localparam int PROD_W     = 2 * COORD_BITS;
  localparam int CNT_W      = $clog2(COORD_BITS);
  localparam int NUM_COORDS = 3;
  localparam int IDX_W      = $clog2(NUM_COORDS);
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_W  = 2'd0,
    REG_CAMERA_W  = 2'd1,
    REG_DEPTH_CUE = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FAULT_OK   = 2'd0,
    FAULT_SAT  = 2'd1,
    FAULT_DIV0 = 2'd2
  } fault_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_START = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [NUM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic                  ovf;
    logic [COORD_BITS-1:0] quot;
  } div_rsp_t;

endpackage

>>> hdl/perspective_project_4d_to_3d.sv
// Projects one 4D vertex into three-space: v * (screen_w - camera_w) / (vw - camera_w).
// Per coordinate the block steps through a multiply state, a divider start state, the
// divider's bit-serial loop (skipped when the quotient overflows 32 bits) and a done step,
// then loads the output register; when vw equals camera_w it goes straight to the output.
// One vertex is in flight at a time; a stalled result holds off the next vertex. Reset is
// asynchronous, active low, and restores the register defaults and zero w extremes.
module perspective_project_4d_to_3d (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [pp4_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [pp4_pkg::COORD_BITS-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [pp4_pkg::COORD_BITS-1:0] vx_i,
  input  logic signed [pp4_pkg::COORD_BITS-1:0] vy_i,
  input  logic signed [pp4_pkg::COORD_BITS-1:0] vz_i,
  input  logic signed [pp4_pkg::COORD_BITS-1:0] vw_i,
  input  logic                                  batch_start_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [pp4_pkg::COORD_BITS-1:0] px_o,
  output logic signed [pp4_pkg::COORD_BITS-1:0] py_o,
  output logic signed [pp4_pkg::COORD_BITS-1:0] pz_o,
  output logic signed [pp4_pkg::COORD_BITS-1:0] w_low_o,
  output logic signed [pp4_pkg::COORD_BITS-1:0] w_high_o,
  output logic [1:0]                            fault_o
);

  localparam int CB = pp4_pkg::COORD_BITS;
  localparam int NW = pp4_pkg::NUM_W;

  pp4_pkg::state_e state_q, state_d;

  logic signed [CB-1:0] screen_w_q, camera_w_q;
  logic                 cue_en_q;
  logic signed [CB-1:0] min_w_q, max_w_q;

  logic signed [CB-1:0] v_q [pp4_pkg::NUM_COORDS];
  logic signed [CB-1:0] res_q [pp4_pkg::NUM_COORDS];
  logic [NW-1:0]        num_mag_q, den_mag_q;
  logic                 sign_nd_q;
  logic                 den_zero_q;
  logic                 sat_acc_q;
  logic                 neg_q;
  logic [pp4_pkg::PROD_W-1:0] prod_q;
  logic [pp4_pkg::IDX_W-1:0]  k_q;
  logic signed [CB-1:0] item_wlo_q, item_whi_q;

  logic                 out_valid_q;
  logic signed [CB-1:0] px_q, py_q, pz_q, wlo_q, whi_q;
  logic [1:0]           fault_q;

  logic                 in_acc;
  logic                 out_load;
  logic signed [NW-1:0] num_s, den_s;
  logic signed [CB-1:0] lo_base, hi_base, min_new, max_new;
  logic signed [CB-1:0] v_sel;
  logic [CB-1:0]        v_mag;
  logic [pp4_pkg::PROD_W:0] prod_full;

  pp4_pkg::div_req_t div_req;
  pp4_pkg::div_rsp_t div_rsp;

  logic          neg_eff;
  logic [CB-1:0] lim, mag_r, res_val;
  logic          sat_now;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != pp4_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == pp4_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);

  assign num_s = {screen_w_q[CB-1], screen_w_q} - {camera_w_q[CB-1], camera_w_q};
  assign den_s = {vw_i[CB-1], vw_i} - {camera_w_q[CB-1], camera_w_q};

  // Batch start clears the extremes before this vertex is folded in.
  assign lo_base = batch_start_i ? '0 : min_w_q;
  assign hi_base = batch_start_i ? '0 : max_w_q;
  assign min_new = (cue_en_q && (vw_i < lo_base)) ? vw_i : lo_base;
  assign max_new = (cue_en_q && (vw_i > hi_base)) ? vw_i : hi_base;

  assign v_sel     = v_q[k_q];
  assign v_mag     = v_sel[CB-1] ? CB'(-v_sel) : v_sel;
  assign prod_full = v_mag * num_mag_q;

  assign div_req.start    = (state_q == pp4_pkg::ST_START);
  assign div_req.dividend = prod_q;
  assign div_req.divisor  = den_mag_q;

  pp4_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // A zero quotient is never negative; an overflowing one is never zero.
  assign neg_eff = neg_q && (div_rsp.ovf || (div_rsp.quot != '0));
  assign lim     = neg_eff ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
  assign sat_now = div_rsp.ovf || (div_rsp.quot > lim);
  assign mag_r   = sat_now ? lim : div_rsp.quot;
  assign res_val = neg_eff ? CB'(-mag_r) : mag_r;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pp4_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (den_s == '0) begin
            state_d = pp4_pkg::ST_OUT;
          end else begin
            state_d = pp4_pkg::ST_MUL;
          end
        end
      end
      pp4_pkg::ST_MUL:   state_d = pp4_pkg::ST_START;
      pp4_pkg::ST_START: state_d = pp4_pkg::ST_WAIT;
      pp4_pkg::ST_WAIT: begin
        if (div_rsp.done) begin
          if (k_q == pp4_pkg::IDX_W'(pp4_pkg::NUM_COORDS - 1)) begin
            state_d = pp4_pkg::ST_OUT;
          end else begin
            state_d = pp4_pkg::ST_MUL;
          end
        end
      end
      pp4_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = pp4_pkg::ST_IDLE;
        end
      end
      default: state_d = pp4_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pp4_pkg::ST_IDLE;
      screen_w_q  <= '0;
      camera_w_q  <= -CB'(196608);
      cue_en_q    <= 1'b0;
      min_w_q     <= '0;
      max_w_q     <= '0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      sat_acc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          pp4_pkg::REG_SCREEN_W:  screen_w_q <= cfg_data_i;
          pp4_pkg::REG_CAMERA_W:  camera_w_q <= cfg_data_i;
          pp4_pkg::REG_DEPTH_CUE: cue_en_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        min_w_q   <= min_new;
        max_w_q   <= max_new;
        k_q       <= '0;
        sat_acc_q <= 1'b0;
      end
      if ((state_q == pp4_pkg::ST_WAIT) && div_rsp.done) begin
        sat_acc_q <= sat_acc_q | sat_now;
        k_q       <= k_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v_q[0]     <= vx_i;
      v_q[1]     <= vy_i;
      v_q[2]     <= vz_i;
      res_q[0]   <= '0;
      res_q[1]   <= '0;
      res_q[2]   <= '0;
      num_mag_q  <= num_s[NW-1] ? NW'(-num_s) : num_s;
      den_mag_q  <= den_s[NW-1] ? NW'(-den_s) : den_s;
      sign_nd_q  <= num_s[NW-1] ^ den_s[NW-1];
      den_zero_q <= (den_s == '0);
      item_wlo_q <= cue_en_q ? min_new : '0;
      item_whi_q <= cue_en_q ? max_new : '0;
    end
    if (state_q == pp4_pkg::ST_MUL) begin
      prod_q <= prod_full[pp4_pkg::PROD_W-1:0];
      neg_q  <= v_sel[CB-1] ^ sign_nd_q;
    end
    if ((state_q == pp4_pkg::ST_WAIT) && div_rsp.done) begin
      res_q[k_q] <= res_val;
    end
    if (out_load) begin
      px_q  <= res_q[0];
      py_q  <= res_q[1];
      pz_q  <= res_q[2];
      wlo_q <= item_wlo_q;
      whi_q <= item_whi_q;
      if (den_zero_q) begin
        fault_q <= pp4_pkg::FAULT_DIV0;
      end else if (sat_acc_q) begin
        fault_q <= pp4_pkg::FAULT_SAT;
      end else begin
        fault_q <= pp4_pkg::FAULT_OK;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign px_o        = px_q;
  assign py_o        = py_q;
  assign pz_o        = pz_q;
  assign w_low_o     = wlo_q;
  assign w_high_o    = whi_q;
  assign fault_o     = fault_q;

endmodule

>>> hdl/pp4_divider.sv
// Iterative restoring divider: one quotient bit per cycle, unsigned.
// Flags overflow when the quotient does not fit in COORD_BITS. Uses pp4_pkg.
module pp4_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pp4_pkg::div_req_t req_i,
  output pp4_pkg::div_rsp_t rsp_o
);

  logic                           busy_q;
  logic                           done_q;
  logic                           ovf_q;
  logic [pp4_pkg::CNT_W-1:0]      cnt_q;
  logic [pp4_pkg::NUM_W-1:0]      rem_q;
  logic [pp4_pkg::NUM_W-1:0]      dvs_q;
  logic [pp4_pkg::COORD_BITS-1:0] low_q;
  logic [pp4_pkg::COORD_BITS-1:0] quot_q;

  logic [pp4_pkg::COORD_BITS-1:0] div_hi;
  logic [pp4_pkg::NUM_W:0]        trial;
  logic [pp4_pkg::NUM_W:0]        diff;
  logic                           fits;
  logic [pp4_pkg::NUM_W-1:0]      rem_d;

  assign div_hi = req_i.dividend[pp4_pkg::PROD_W-1:pp4_pkg::COORD_BITS];
  assign trial  = {rem_q, low_q[pp4_pkg::COORD_BITS-1]};
  assign diff   = trial - {1'b0, dvs_q};
  assign fits   = ~diff[pp4_pkg::NUM_W];
  // The remainder stays below the divisor, so it always fits NUM_W bits.
  assign rem_d  = fits ? diff[pp4_pkg::NUM_W-1:0] : trial[pp4_pkg::NUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        // The quotient fits COORD_BITS exactly when the upper half of the
        // dividend is below the divisor.
        if ({1'b0, div_hi} >= req_i.divisor) begin
          ovf_q  <= 1'b1;
          done_q <= 1'b1;
        end else begin
          ovf_q  <= 1'b0;
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == pp4_pkg::CNT_W'(pp4_pkg::COORD_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      rem_q <= {1'b0, div_hi};
      low_q <= req_i.dividend[pp4_pkg::COORD_BITS-1:0];
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      low_q  <= {low_q[pp4_pkg::COORD_BITS-2:0], 1'b0};
      quot_q <= {quot_q[pp4_pkg::COORD_BITS-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quot = quot_q;

endmodule

>>> hdl/pp4_checker.sv
// Port-level checks for perspective_project_4d_to_3d, bound to the top level.
// Uses pp4_pkg for the fault codes.
module pp4_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [pp4_pkg::COORD_BITS-1:0] px_o,
  input logic signed [pp4_pkg::COORD_BITS-1:0] py_o,
  input logic signed [pp4_pkg::COORD_BITS-1:0] pz_o,
  input logic [1:0]                            fault_o
);

  // The block works on one vertex at a time, so an accepted transaction
  // always makes it busy in the next cycle.
  busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while block did not go busy");

  // A divide fault carries an all-zero projected vertex.
  div_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (fault_o == pp4_pkg::FAULT_DIV0)) |->
      (px_o == '0) && (py_o == '0) && (pz_o == '0))
    else $error("divide fault with nonzero result");

  // New results are only loaded while a vertex is in progress.
  result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a vertex in progress");

  stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(px_o) && $stable(py_o) && $stable(pz_o) && $stable(fault_o)))
    else $error("stalled result changed");

endmodule

bind perspective_project_4d_to_3d pp4_checker u_pp4_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .px_o        (px_o),
  .py_o        (py_o),
  .pz_o        (pz_o),
  .fault_o     (fault_o)
);

>>> verif/testbench.sv
// Self-checking testbench for perspective_project_4d_to_3d: directed vertices, then random
// vertices under several projection settings, each result checked against a local model or a typed result.
// Depends on pp4_pkg and the block's RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pp4_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 8;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_REPORTS     = 10;
  localparam int SMALL_SPAN      = 1048576;  // 16.0 in Q15.16

  localparam logic [CFG_IDX_W-1:0]         REG_UNUSED     = 2'd3;
  localparam logic signed [COORD_BITS-1:0] COORD_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_BITS-1:0] COORD_MIN      = 32'sh8000_0000;
  localparam logic signed [COORD_BITS-1:0] ONE            = 32'sd65536;
  localparam logic signed [COORD_BITS-1:0] CAMERA_W_RESET = -32'sd196608;
  localparam logic signed [127:0]          WIDE_MAX       = 128'sh7FFF_FFFF;
  localparam logic signed [127:0]          WIDE_MIN       = -128'sh8000_0000;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic signed [COORD_BITS-1:0] vz;
    logic signed [COORD_BITS-1:0] vw;
    logic                         batch_start;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] pz;
    logic signed [COORD_BITS-1:0] w_low;
    logic signed [COORD_BITS-1:0] w_high;
    logic [1:0]                   fault;
  } projection_t;

  typedef struct packed {
    logic                  is_config;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [COORD_BITS-1:0] reg_value;
    vertex_t               vtx;
    logic                  known;
    projection_t           want;
  } directed_row_t;

  logic                         clk_i;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  logic [CFG_IDX_W-1:0]         cfg_index_i   = '0;
  logic [COORD_BITS-1:0]        cfg_data_i    = '0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_stall_o;
  logic signed [COORD_BITS-1:0] vx_i          = '0;
  logic signed [COORD_BITS-1:0] vy_i          = '0;
  logic signed [COORD_BITS-1:0] vz_i          = '0;
  logic signed [COORD_BITS-1:0] vw_i          = '0;
  logic                         batch_start_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i   = 1'b0;
  logic signed [COORD_BITS-1:0] px_o;
  logic signed [COORD_BITS-1:0] py_o;
  logic signed [COORD_BITS-1:0] pz_o;
  logic signed [COORD_BITS-1:0] w_low_o;
  logic signed [COORD_BITS-1:0] w_high_o;
  logic [1:0]                   fault_o;

  // Local copy of the block's registers and w extremes.
  logic signed [COORD_BITS-1:0] proj_screen_w = '0;
  logic signed [COORD_BITS-1:0] proj_camera_w = CAMERA_W_RESET;
  logic                         proj_depth_cue = 1'b0;
  logic signed [COORD_BITS-1:0] batch_w_min = '0;
  logic signed [COORD_BITS-1:0] batch_w_max = '0;

  projection_t   pending_projections[$];
  directed_row_t directed_rows[$];

  stall_mode_e stall_mode     = STALL_NONE;
  int          stall_period   = 16;
  int          stall_duty     = 4;
  int          stall_tick     = 0;
  int          sender_max_gap = 0;
  int          burst_left     = 0;
  bit          valid_held     = 1'b0;

  int vertices_sent   = 0;
  int results_checked = 0;
  int register_writes = 0;
  int div0_count      = 0;
  int sat_count       = 0;
  int batch_count     = 0;
  int mismatch_count  = 0;

  perspective_project_4d_to_3d dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .vx_i          (vx_i),
    .vy_i          (vy_i),
    .vz_i          (vz_i),
    .vw_i          (vw_i),
    .batch_start_i (batch_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .px_o          (px_o),
    .py_o          (py_o),
    .pz_o          (pz_o),
    .w_low_o       (w_low_o),
    .w_high_o      (w_high_o),
    .fault_o       (fault_o)
  );

  always begin
    clk_i = 1'b0;
    #CLK_HALF;
    clk_i = 1'b1;
    #CLK_HALF;
  end

  // The product of a 32-bit coordinate and a 33-bit difference needs 65 bits, so the division runs at 128 bits.
  function automatic logic signed [COORD_BITS-1:0] scale_coord(
      input logic signed [COORD_BITS-1:0] coord, input logic signed [NUM_W-1:0] num,
      input logic signed [NUM_W-1:0] den, output logic sat);
    logic signed [127:0] wide_coord, wide_num, wide_den, quotient;
    wide_coord = coord;
    wide_num   = num;
    wide_den   = den;
    quotient   = (wide_coord * wide_num) / wide_den;
    sat        = 1'b0;
    if (quotient > WIDE_MAX) begin
      sat = 1'b1;
      return COORD_MAX;
    end
    if (quotient < WIDE_MIN) begin
      sat = 1'b1;
      return COORD_MIN;
    end
    return quotient[COORD_BITS-1:0];
  endfunction

  function automatic projection_t project_vertex(input vertex_t v);
    projection_t              r;
    logic signed [NUM_W-1:0]  num, den;
    logic signed [COORD_BITS-1:0] w;
    logic                     sat_x, sat_y, sat_z;
    w   = v.vw;
    num = {proj_screen_w[COORD_BITS-1], proj_screen_w}
        - {proj_camera_w[COORD_BITS-1], proj_camera_w};
    den = {w[COORD_BITS-1], w} - {proj_camera_w[COORD_BITS-1], proj_camera_w};
    // A batch start clears the extremes before this vertex's w is taken in.
    if (v.batch_start) begin
      batch_w_min = '0;
      batch_w_max = '0;
    end
    if (proj_depth_cue) begin
      if (w < batch_w_min) batch_w_min = w;
      if (w > batch_w_max) batch_w_max = w;
    end
    if (den == 0) begin
      r.px    = '0;
      r.py    = '0;
      r.pz    = '0;
      r.fault = FAULT_DIV0;
    end else begin
      r.px    = scale_coord(v.vx, num, den, sat_x);
      r.py    = scale_coord(v.vy, num, den, sat_y);
      r.pz    = scale_coord(v.vz, num, den, sat_z);
      r.fault = (sat_x || sat_y || sat_z) ? FAULT_SAT : FAULT_OK;
    end
    r.w_low  = proj_depth_cue ? batch_w_min : '0;
    r.w_high = proj_depth_cue ? batch_w_max : '0;
    return r;
  endfunction

  function automatic logic [COORD_BITS-1:0] small_value();
    return $urandom_range(0, 2 * SMALL_SPAN) - SMALL_SPAN;
  endfunction

  function automatic logic [COORD_BITS-1:0] random_coord();
    case ($urandom_range(9))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      3, 4, 5: return small_value();
      default: return $urandom();
    endcase
  endfunction

  // Steers w toward the camera plane so that divide faults and saturation come up often.
  function automatic logic [COORD_BITS-1:0] random_w();
    case ($urandom_range(11))
      0:       return proj_camera_w;
      1, 2:    return $urandom_range(1) ? proj_camera_w + $urandom_range(1, 255)
                                        : proj_camera_w - $urandom_range(1, 255);
      3:       return COORD_MAX;
      4:       return COORD_MIN;
      5, 6, 7: return proj_camera_w + small_value();
      default: return $urandom();
    endcase
  endfunction

  function automatic void add_vertex(input logic [COORD_BITS-1:0] vx, vy, vz, vw,
                                     input logic batch_start);
    directed_row_t row;
    row                   = '0;
    row.vtx.vx            = vx;
    row.vtx.vy            = vy;
    row.vtx.vz            = vz;
    row.vtx.vw            = vw;
    row.vtx.batch_start   = batch_start;
    directed_rows         = {directed_rows, row};
  endfunction

  // Rows with a typed result all run with depth cueing off, so w_low and w_high are zero.
  function automatic void add_known(input logic [COORD_BITS-1:0] vx, vy, vz, vw,
                                    input logic batch_start,
                                    input logic [COORD_BITS-1:0] px, py, pz,
                                    input logic [1:0] fault);
    directed_row_t row;
    add_vertex(vx, vy, vz, vw, batch_start);
    row              = directed_rows.pop_back();
    row.known        = 1'b1;
    row.want.px      = px;
    row.want.py      = py;
    row.want.pz      = pz;
    row.want.w_low   = '0;
    row.want.w_high  = '0;
    row.want.fault   = fault;
    directed_rows    = {directed_rows, row};
  endfunction

  function automatic void add_config(input logic [CFG_IDX_W-1:0] index,
                                     input logic [COORD_BITS-1:0] value);
    directed_row_t row;
    row           = '0;
    row.is_config = 1'b1;
    row.reg_index = index;
    row.reg_value = value;
    directed_rows = {directed_rows, row};
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [COORD_BITS-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (index)
      REG_SCREEN_W:  proj_screen_w  = value;
      REG_CAMERA_W:  proj_camera_w  = value;
      REG_DEPTH_CUE: proj_depth_cue = value[0];
      default:       ;
    endcase
    register_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Called at a falling edge; returns at a falling edge with valid still high unless a
  // gap was taken, so that back-to-back transactions keep valid asserted.
  task automatic send_vertex(input vertex_t v, input logic known, input projection_t want);
    projection_t predicted;
    int          gap;
    in_valid_i    <= 1'b1;
    vx_i          <= v.vx;
    vy_i          <= v.vy;
    vz_i          <= v.vz;
    vw_i          <= v.vw;
    batch_start_i <= v.batch_start;
    valid_held    = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = project_vertex(v);
    pending_projections = {pending_projections, (known ? want : predicted)};
    vertices_sent++;
    if (predicted.fault == FAULT_DIV0) div0_count++;
    if (predicted.fault == FAULT_SAT) sat_count++;
    if (v.batch_start) batch_count++;
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(15);
      gap = (sender_max_gap == 0) ? 0 : $urandom_range(1, sender_max_gap);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        valid_held = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // Registers may only change once every pending result has left the block.
  task automatic wait_for_idle();
    if (valid_held) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
    end
    while (pending_projections.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      STALL_NONE:   out_stall_i <= 1'b0;
      STALL_RANDOM: out_stall_i <= ($urandom_range(3) == 0);
      default:      out_stall_i <= ((stall_tick % stall_period) < stall_duty);
    endcase
  end

  always @(posedge clk_i) begin : result_check
    projection_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.px     = px_o;
      got.py     = py_o;
      got.pz     = pz_o;
      got.w_low  = w_low_o;
      got.w_high = w_high_o;
      got.fault  = fault_o;
      if (pending_projections.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("Unexpected result transaction: px %h py %h pz %h w_low %h w_high %h fault %0d",
                   got.px, got.py, got.pz, got.w_low, got.w_high, got.fault);
      end else begin
        want = pending_projections.pop_front();
        results_checked++;
        if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz ||
            got.w_low !== want.w_low || got.w_high !== want.w_high ||
            got.fault !== want.fault) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("Result %0d mismatch at %0t", results_checked, $realtime);
            $display("  expected px %h py %h pz %h w_low %h w_high %h fault %0d",
                     want.px, want.py, want.pz, want.w_low, want.w_high, want.fault);
            $display("  actual   px %h py %h pz %h w_low %h w_high %h fault %0d",
                     got.px, got.py, got.pz, got.w_low, got.w_high, got.fault);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("No transaction for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_projections.size());
    $display("testbench failed");
    $finish;
  end

  initial begin : stimulus
    vertex_t                v;
    logic [COORD_BITS-1:0]  screen, camera, cue_word;
    int                     phase;

    // Reset settings: screen at 0 and camera at -3.0, so num / den is 1 at w = 0.
    add_known('0, '0, '0, '0, 1'b0, '0, '0, '0, FAULT_OK);
    add_known(COORD_MAX, COORD_MIN, 1, '0, 1'b0, COORD_MAX, COORD_MIN, 1, FAULT_OK);
    add_known(ONE, -ONE, '0, CAMERA_W_RESET, 1'b0, '0, '0, '0, FAULT_DIV0);
    add_known(COORD_MAX, COORD_MIN, '0, CAMERA_W_RESET + 1, 1'b0,
              COORD_MAX, COORD_MIN, '0, FAULT_SAT);
    add_known(1, -1, 2, CAMERA_W_RESET + 1, 1'b0, 196608, -196608, 393216, FAULT_OK);
    // A scale of one half truncates toward zero on both sides.
    add_known(3, -3, '0, 196608, 1'b0, 1, -1, '0, FAULT_OK);
    add_vertex(COORD_MAX, COORD_MIN, -1, COORD_MAX, 1'b0);
    add_vertex(COORD_MIN, COORD_MAX, 1, COORD_MIN, 1'b1);
    add_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'h1234_5678, 1'b0);
    add_config(REG_DEPTH_CUE, 32'hFFFF_FFFF);
    add_vertex(ONE, ONE, ONE, 5 * ONE, 1'b1);
    add_vertex(2 * ONE, -ONE, '0, -2 * ONE, 1'b0);
    add_vertex('0, '0, '0, CAMERA_W_RESET, 1'b0);
    add_vertex(1, 1, 1, COORD_MAX, 1'b0);
    add_vertex(1, 1, 1, COORD_MIN, 1'b0);
    add_vertex(ONE, ONE, ONE, ONE, 1'b1);
    add_config(REG_UNUSED, 32'hFFFF_FFFF);
    add_config(REG_SCREEN_W, COORD_MAX);
    add_config(REG_CAMERA_W, COORD_MIN);
    add_vertex(1, -1, COORD_MAX, COORD_MAX, 1'b0);
    add_vertex(COORD_MAX, COORD_MIN, '0, COORD_MIN + 1, 1'b0);
    add_config(REG_SCREEN_W, COORD_MIN);
    add_config(REG_CAMERA_W, COORD_MAX);
    add_vertex(COORD_MIN, COORD_MAX, 1, '0, 1'b0);
    add_vertex(1, 2, 3, COORD_MAX, 1'b0);
    add_config(REG_DEPTH_CUE, 32'hFFFF_FFFE);
    add_vertex(7, -7, '0, 7, 1'b1);

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    stall_mode     = STALL_RANDOM;
    sender_max_gap = 40;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_config) begin
        wait_for_idle();
        write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
      end else begin
        send_vertex(directed_rows[i].vtx, directed_rows[i].known, directed_rows[i].want);
      end
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_idle();
      case (phase)
        0: begin
          screen = '0;
          camera = CAMERA_W_RESET;
          cue_word = 1;
        end
        1: begin
          screen = COORD_MAX;
          camera = COORD_MIN;
          cue_word = 1;
        end
        2: begin
          screen = COORD_MIN;
          camera = COORD_MAX;
          cue_word = 0;
        end
        3: begin
          // Screen on the camera plane: every projection collapses to zero.
          screen = $urandom();
          camera = screen;
          cue_word = 1;
        end
        4, 6: begin
          screen = small_value();
          camera = small_value();
          cue_word = (phase == 4);
        end
        default: begin
          screen = $urandom();
          camera = $urandom();
          cue_word = $urandom_range(1);
        end
      endcase
      cue_word[COORD_BITS-1:1] = $urandom();
      write_register(REG_SCREEN_W, screen);
      write_register(REG_CAMERA_W, camera);
      write_register(REG_DEPTH_CUE, cue_word);
      write_register(REG_UNUSED, $urandom());

      stall_mode   = stall_mode_e'(phase % 3);
      stall_period = $urandom_range(8, 97);
      stall_duty   = $urandom_range(1, stall_period - 1);
      case (phase % 4)
        0:       sender_max_gap = 150;
        1:       sender_max_gap = 12;
        2:       sender_max_gap = 0;
        default: sender_max_gap = 60;
      endcase

      repeat (ITEMS_PER_PHASE) begin
        v.vx          = random_coord();
        v.vy          = random_coord();
        v.vz          = random_coord();
        v.vw          = random_w();
        v.batch_start = ($urandom_range(11) == 0);
        send_vertex(v, 1'b0, '0);
      end
    end

    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Projected %0d vertices (%0d batch starts) with %0d register writes; %0d results compared.",
             vertices_sent, batch_count, register_writes, results_checked);
    $display("Covered %0d divide faults and %0d saturated results; %0d mismatches.",
             div0_count, sat_count, mismatch_count);
    if (mismatch_count == 0 && pending_projections.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
